/* design/bprs_pkg.sv */
// ----------------------------------------------------------------------------
// bprs_pkg
// Shared types and codes for the blocked prefix range sum core.
// ----------------------------------------------------------------------------
package bprs_pkg;

  localparam int BLOCK_SIZE = 32;
  localparam int NUM_BLOCKS = 32;

  typedef enum logic [2:0] {
    KIND_CLEAR = 3'd0,
    KIND_LOAD  = 3'd1,
    KIND_ADD   = 3'd2,
    KIND_SUB   = 3'd3,
    KIND_QUERY = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [10:0] position;
    logic [15:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] range_sum;
    logic               status;
  } rsp_t;

endpackage

/* design/bprs_if.sv */
// ----------------------------------------------------------------------------
// bprs_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bprs_req_if;
  logic              valid;
  logic              ready;
  bprs_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bprs_rsp_if;
  logic              valid;
  logic              ready;
  bprs_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/bprs_queue.sv */
// ----------------------------------------------------------------------------
// bprs_queue
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
module bprs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bprs_pkg::req_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bprs_pkg::req_t pop_data_o
);
  import bprs_pkg::*;

  req_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end
endmodule

/* design/bprs_front.sv */
// ----------------------------------------------------------------------------
// bprs_front
// Accepts requests, drops unused kinds and pushes the rest to the queue.
// ----------------------------------------------------------------------------
module bprs_front (
  bprs_req_if.sink       in_if,
  output logic           push_o,
  output bprs_pkg::req_t push_data_o,
  input  logic           full_i
);
  import bprs_pkg::*;

  logic known;
  assign known       = in_if.data.kind <= KIND_QUERY;
  assign in_if.ready = !full_i;
  assign push_o      = in_if.valid && !full_i && known;
  assign push_data_o = in_if.data;
endmodule

/* design/bprs_back.sv */
// ----------------------------------------------------------------------------
// bprs_back
// Sequencer over the prefix store: clears, loads, block updates and range walks.
// ----------------------------------------------------------------------------
module bprs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  bprs_pkg::req_t req_i,
  output logic           pop_o,
  bprs_rsp_if.source     out_if
);
  import bprs_pkg::*;

  localparam int OW  = $clog2(BLOCK_SIZE);
  localparam int BW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CAP = BLOCK_SIZE * NUM_BLOCKS;
  localparam int CW  = $clog2(CAP + 1);
  localparam int AW  = BW + OW;
  localparam int DEPTH = NUM_BLOCKS * BLOCK_SIZE;

  typedef enum logic [3:0] {
    S_IDLE, S_LDRD, S_LDWR, S_UPRD, S_UPWR, S_QRD, S_QACC, S_OUT
  } state_e;

  state_e st_q, st_d;
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;
  logic [AW-1:0] raddr, waddr;
  logic [31:0] wdata;
  logic        we, re;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   val_q, val_d, acc_q, acc_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] eaddr_q, eaddr_d;
  logic [1:0]    ph_q, ph_d;
  logic          first_q, first_d;
  logic          zero_rd_q, zero_rd_d;
  rsp_t          rsp_q, rsp_d;
  logic          ov_q, ov_d;

  logic [AW-1:0] pz, ez, lz;
  logic [31:0]   rd;
  assign pz = AW'(req_i.position - 11'd1);
  assign ez = AW'(req_i.operand_b - 16'd1);
  assign lz = AW'(cnt_q);
  assign rd = zero_rd_q ? 32'd0 : rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d; acc_q <= acc_d; addr_q <= addr_d; eaddr_q <= eaddr_d;
    ph_q <= ph_d; first_q <= first_d; zero_rd_q <= zero_rd_d; rsp_q <= rsp_d;
  end

  assign out_if.valid = ov_q;
  assign out_if.data  = rsp_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; val_d = val_q; acc_d = acc_q;
    addr_d = addr_q; eaddr_d = eaddr_q; ph_d = ph_q; first_d = first_q;
    zero_rd_d = zero_rd_q; rsp_d = rsp_q; ov_d = ov_q;
    pop_o = 1'b0; we = 1'b0; re = 1'b0;
    raddr = addr_q; waddr = addr_q; wdata = val_q;
    if (ov_q && out_if.ready) ov_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (!empty_i && !ov_q) begin
          pop_o = 1'b1;
          val_d = 32'(req_i.operand_b);
          case (req_i.kind)
            KIND_CLEAR: cnt_d = '0;
            KIND_LOAD: begin
              if (32'(cnt_q) < CAP) begin
                addr_d = lz;
                raddr = lz - AW'(1);
                re = 1'b1;
                zero_rd_d = lz[OW-1:0] == '0;
                st_d = S_LDRD;
              end
            end
            KIND_ADD, KIND_SUB: begin
              if (req_i.position != 11'd0 && 32'(req_i.position) <= 32'(cnt_q)) begin
                if (req_i.kind == KIND_SUB) val_d = 32'd0 - 32'(req_i.operand_b);
                addr_d = pz; raddr = pz; re = 1'b1; zero_rd_d = 1'b0;
                st_d = S_UPRD;
              end
            end
            KIND_QUERY: begin
              if (req_i.position == 11'd0 || 16'(req_i.position) > req_i.operand_b ||
                  32'(req_i.operand_b) > 32'(cnt_q)) begin
                rsp_d = '{range_sum: 32'sd0, status: 1'b1};
                st_d = S_OUT;
              end else begin
                acc_d = '0; eaddr_d = ez; first_d = 1'b1; ph_d = 2'd0;
                addr_d = pz - AW'(1);
                raddr = pz - AW'(1); re = 1'b1;
                zero_rd_d = pz[OW-1:0] == '0;
                st_d = S_QRD;
                if (pz[AW-1:OW] == ez[AW-1:OW]) ph_d = 2'd3;
                addr_d = pz;
              end
            end
            default: ;
          endcase
        end
      end
      S_LDRD: st_d = S_LDWR;
      S_LDWR: begin
        we = 1'b1; waddr = addr_q; wdata = rd + val_q;
        cnt_d = cnt_q + CW'(1);
        st_d = S_IDLE;
      end
      S_UPRD: st_d = S_UPWR;
      S_UPWR: begin
        we = 1'b1; waddr = addr_q; wdata = rdata_q + val_q;
        if (addr_q[OW-1:0] == OW'(BLOCK_SIZE - 1)) st_d = S_IDLE;
        else begin
          addr_d = addr_q + AW'(1); raddr = addr_q + AW'(1); re = 1'b1;
          st_d = S_UPRD;
        end
      end
      S_QRD: st_d = S_QACC;
      S_QACC: begin
        // first read is the prefix before start: subtract it
        if (first_q) acc_d = acc_q - rd;
        else acc_d = acc_q + rdata_q;
        first_d = 1'b0; zero_rd_d = 1'b0;
        if (!first_q && ph_q == 2'd2) begin
          rsp_d = '{range_sum: $signed(acc_q + rdata_q), status: 1'b0};
          st_d = S_OUT;
        end else begin
          st_d = S_QRD; re = 1'b1;
          if (ph_q == 2'd3) begin
            raddr = eaddr_q;
            ph_d = 2'd2;
          end else begin
            // walk block totals from start block until end block
            if (first_q) raddr = {addr_q[AW-1:OW], OW'(BLOCK_SIZE - 1)};
            else raddr = {addr_q[AW-1:OW] + BW'(1), OW'(BLOCK_SIZE - 1)};
            if (!first_q) addr_d = {addr_q[AW-1:OW] + BW'(1), OW'(0)};
            if ((first_q ? addr_q[AW-1:OW] : addr_q[AW-1:OW] + BW'(1)) + BW'(1)
                == eaddr_q[AW-1:OW]) ph_d = 2'd3;
          end
        end
      end
      S_OUT: begin
        ov_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end
endmodule

/* design/blocked_prefix_range_sum_core.sv */
// ----------------------------------------------------------------------------
// blocked_prefix_range_sum_core
// Point update, range sum array kept as blocks of running prefix sums.
// ----------------------------------------------------------------------------
// Requests pass a two-entry queue into a sequencer over one prefix memory
// with registered reads, one read and one write port. Block size and block
// count are package constants. Once taken, a load reads the prior prefix and
// writes the new one; an add or subtract rewrites each prefix entry from the
// target to its block end; a flagged query reads nothing, and a valid query
// reads the prefix before its start, the block totals up to its end block and
// its end entry before its result is offered; the next request waits until
// that result is taken. The memory needs no clearing after reset.
module blocked_prefix_range_sum_core (
  input logic        clk_i,
  input logic        rst_ni,
  bprs_req_if.sink   in_if,
  bprs_rsp_if.source out_if
);
  import bprs_pkg::*;

  logic push, full, pop, empty;
  req_t push_data, pop_data;

  bprs_front u_front (.in_if(in_if), .push_o(push), .push_data_o(push_data), .full_i(full));

  bprs_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(pop_data)
  );

  bprs_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .req_i(pop_data), .pop_o(pop), .out_if(out_if)
  );
endmodule

/* design/bprs_checker.sv */
// ----------------------------------------------------------------------------
// bprs_checker
// Port level checks for the blocked prefix range sum core.
// ----------------------------------------------------------------------------
module bprs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_sum_i,
  input logic        out_status_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sum_i))
    else $error("result dropped");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i |-> out_sum_i == 32'd0)
    else $error("flagged query with nonzero sum");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> !out_valid_i)
    else $error("back to back results");
endmodule

bind blocked_prefix_range_sum_core bprs_checker u_chk (
  .clk_i, .rst_ni, .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .out_sum_i(out_if.data.range_sum), .out_status_i(out_if.data.status)
);

/* tb/blocked_prefix_range_sum_core_tb.sv */
// ----------------------------------------------------------------------------
// blocked_prefix_range_sum_core_tb
// Drives clear, load, add, subtract, query and unused-kind transactions into the core,
// predicts every query answer from a local copy of the block prefix store,
// and compares each response field by field under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blocked_prefix_range_sum_core_tb;
  import bprs_pkg::*;

  localparam int BLK  = BLOCK_SIZE;
  localparam int NBLK = NUM_BLOCKS;
  localparam int CAP  = BLK * NBLK;
  localparam int FILL = 10 * BLK;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bprs_req_if req_ch ();
  bprs_rsp_if rsp_ch ();

  blocked_prefix_range_sum_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (req_ch.sink),
    .out_if(rsp_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [31:0] prefix_mdl [NBLK][BLK+1];
  int          elem_count;
  int          hi_water;
  rsp_t        pending_sums[$];
  int          errors;
  bit          idle_en;
  int          rsp_hold;
  int          hold_reqs;
  int          hold_seen;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    errors       = 0;
    idle_en      = 1'b1;
    rsp_hold     = 0;
    hold_reqs    = 0;
    hold_seen    = 0;
    elem_count   = 0;
    hi_water     = 0;
    for (int b = 0; b < NBLK; b++) begin
      for (int k = 0; k <= BLK; k++) prefix_mdl[b][k] = '0;
    end
  end

  function automatic void split_pos(input int pos, output int blk, output int off);
    blk = ((pos - 1) / BLK) % NBLK;
    off = (pos - 1) % BLK + 1;
  endfunction

  function automatic void apply_amount(input int pos, input logic [31:0] amt);
    int blk, off;
    if (pos == 0 || pos > elem_count) return;
    split_pos(pos, blk, off);
    for (int k = off; k <= BLK; k++) prefix_mdl[blk][k] += amt;
  endfunction

  function automatic logic [31:0] range_total(input int s, input int e);
    int bs, os, be, oe;
    logic [31:0] acc;
    split_pos(s, bs, os);
    split_pos(e, be, oe);
    if (bs == be) return prefix_mdl[be][oe] - prefix_mdl[bs][os-1];
    acc = prefix_mdl[bs][BLK] - prefix_mdl[bs][os-1];
    for (int b = bs + 1; b < be; b++) acc += prefix_mdl[b][BLK];
    return acc + prefix_mdl[be][oe];
  endfunction

  // an update walks to its block end, so that end must already be written
  function automatic bit walk_unsafe(input int pos);
    return pos > 0 && pos <= elem_count && ((pos - 1) / BLK + 1) * BLK > hi_water;
  endfunction

  function automatic void predict_txn(input req_t rq);
    rsp_t ans;
    int blk, off;
    int pos, opb;
    pos = rq.position;
    opb = rq.operand_b;
    case (rq.kind)
      KIND_CLEAR: elem_count = 0;
      KIND_LOAD: begin
        if (elem_count < CAP) begin
          elem_count++;
          if (elem_count > hi_water) hi_water = elem_count;
          split_pos(elem_count, blk, off);
          prefix_mdl[blk][off] = prefix_mdl[blk][off-1] + 32'(opb);
        end
      end
      KIND_ADD: apply_amount(pos, 32'(opb));
      KIND_SUB: apply_amount(pos, 32'd0 - 32'(opb));
      KIND_QUERY: begin
        if (pos == 0 || pos > opb || opb > elem_count) begin
          ans.range_sum = '0;
          ans.status    = 1'b1;
        end else begin
          ans.range_sum = range_total(pos, opb);
          ans.status    = 1'b0;
        end
        pending_sums.push_back(ans);
      end
      default: ;
    endcase
  endfunction

  task automatic send_txn(input logic [2:0] kind, input int pos, input int opb);
    req_t rq;
    int gap;
    rq.kind      = kind;
    rq.position  = 11'(pos);
    rq.operand_b = 16'(opb);
    gap = 0;
    if (idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= rq;
    do @(posedge clk_i); while (!req_ch.ready);
    predict_txn(rq);
  endtask

  task automatic stop_sending();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_sums.size() != 0) @(posedge clk_i);
  endtask

  // response side: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen    <= hold_reqs;
      rsp_hold     <= 400;
      rsp_ch.ready <= 1'b0;
    end else if (rsp_hold > 0) begin
      rsp_hold     <= rsp_hold - 1;
      rsp_ch.ready <= 1'b0;
    end else if (idle_en && rsp_ch.ready && $urandom_range(0, 7) == 0) begin
      rsp_hold     <= $urandom_range(1, 14);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_sums.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction sum=%0d status=%0b", $time,
                 rsp_ch.data.range_sum, rsp_ch.data.status);
      end else begin
        exp_r = pending_sums.pop_front();
        if (rsp_ch.data.range_sum !== exp_r.range_sum) begin
          errors++;
          $display("%0t: range_sum expected %0d actual %0d", $time,
                   exp_r.range_sum, rsp_ch.data.range_sum);
        end
        if (rsp_ch.data.status !== exp_r.status) begin
          errors++;
          $display("%0t: status expected %0b actual %0b", $time,
                   exp_r.status, rsp_ch.data.status);
        end
      end
    end
  end

  // whole blocks get written before any update can walk past the count
  task automatic test_fill();
    for (int i = 0; i < FILL; i++) send_txn(KIND_LOAD, 0, $urandom_range(0, 65535));
    send_txn(KIND_QUERY, 1, FILL);
    send_txn(KIND_ADD, FILL, 16'hffff);
    send_txn(KIND_QUERY, 1, FILL);
  endtask

  task automatic test_directed();
    send_txn(KIND_CLEAR, 0, 0);
    send_txn(KIND_QUERY, 1, 1);
    for (int i = 0; i < 70; i++) send_txn(KIND_LOAD, 0, (i == 0) ? 16'hffff : i);
    send_txn(KIND_QUERY, 1, 1);
    send_txn(KIND_QUERY, 3, 20);
    send_txn(KIND_QUERY, 5, 70);
    send_txn(KIND_QUERY, 32, 33);
    send_txn(KIND_QUERY, 0, 5);
    send_txn(KIND_QUERY, 9, 8);
    send_txn(KIND_QUERY, 1, 71);
    send_txn(KIND_QUERY, 11'h7ff, 16'hffff);
    send_txn(KIND_ADD, 1, 16'hffff);
    send_txn(KIND_SUB, 33, 16'hffff);
    send_txn(KIND_ADD, 0, 100);
    send_txn(KIND_SUB, 71, 100);
    send_txn(KIND_ADD, 70, 1);
    send_txn(3'd5, 1, 1);
    send_txn(3'd6, 11'h7ff, 16'hffff);
    send_txn(3'd7, 2, 2);
    send_txn(KIND_QUERY, 1, 70);
    send_txn(KIND_QUERY, 33, 64);
  endtask

  task automatic random_txn();
    int r, s, e, p;
    logic [2:0] k;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_txn(KIND_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 65535));
    end else if (r < 24) begin
      send_txn(KIND_LOAD, $urandom_range(0, 2047), $urandom_range(0, 65535));
    end else if (r < 52) begin
      s = (elem_count > 0) ? $urandom_range(1, elem_count) : 0;
      if (walk_unsafe(s)) s = 0;
      send_txn((r < 38) ? KIND_ADD : KIND_SUB, s, $urandom_range(0, 65535));
    end else if (r < 90) begin
      if (elem_count > 0) begin
        e = $urandom_range(1, elem_count);
        s = $urandom_range(1, e);
        if ($urandom_range(0, 3) == 0) s = e - $urandom_range(0, (e - 1) % BLK);
        send_txn(KIND_QUERY, s, e);
      end else begin
        send_txn(KIND_QUERY, $urandom_range(0, 3), $urandom_range(0, 3));
      end
    end else if (r < 95) begin
      k = 3'($urandom_range(2, 4));
      p = $urandom_range(0, 2047);
      if (k != KIND_QUERY && walk_unsafe(p)) p = 0;
      send_txn(k, p, $urandom_range(0, 65535));
    end else begin
      send_txn(3'($urandom_range(5, 7)), $urandom_range(0, 2047), $urandom_range(0, 65535));
    end
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    for (int i = 0; i < 30; i++) send_txn(KIND_QUERY, 1, $urandom_range(1, elem_count));
  endtask

  task automatic test_pause();
    stop_sending();
    wait_drained();
    for (int i = 0; i < 10; i++) random_txn();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) random_txn();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill();
    test_directed();
    test_backpressure();
    test_pause();
    test_random(250);
    idle_en = 1'b0;
    test_random(100);
    stop_sending();
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
